// ----- rtl/msc_pkg.sv -----
// Package for the media signature carver: request and response payload types,
// signature bytes, record constants and the controller/datapath interface structs.
// Depends on nothing; every other file imports it.
package msc_pkg;

   localparam int DATA_W     = 8;
   localparam int BASE_W     = 48;
   localparam int START_W    = 49;
   localparam int FILE_LEN_W = 25;
   localparam int KIND_W     = 2;
   localparam int CONF_W     = 7;

   // The scan looks at eight consecutive stored bytes at a time.
   localparam int WIN_BYTES = 8;
   localparam logic [3:0] WIN_FILL = 4'd8;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_JPEG = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PNG  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MP4  = 2'd3;

   localparam logic [CONF_W-1:0] CONF_EXACT   = 7'd90;
   localparam logic [CONF_W-1:0] CONF_DEFAULT = 7'd50;
   localparam logic [CONF_W-1:0] CONF_MP4     = 7'd60;

   localparam logic [FILE_LEN_W-1:0] LEN_DEFAULT = FILE_LEN_W'(2 * 1024 * 1024);
   localparam logic [FILE_LEN_W-1:0] LEN_MP4     = FILE_LEN_W'(25 * 1024 * 1024);

   localparam int SKIP_NO_FOOTER = 1025;
   localparam int SKIP_MP4       = 1024 * 1024 + 1;

   // Signature bytes.
   localparam logic [7:0] JPG_MARK = 8'hFF;
   localparam logic [7:0] JPG_SOI  = 8'hD8;
   localparam logic [7:0] JPG_EOI  = 8'hD9;
   localparam logic [7:0] PNG_SIG0 = 8'h89;
   localparam logic [7:0] PNG_SIG1 = 8'h50;
   localparam logic [7:0] PNG_SIG2 = 8'h4E;
   localparam logic [7:0] PNG_SIG3 = 8'h47;
   localparam logic [7:0] IEND_0   = 8'h49;
   localparam logic [7:0] IEND_1   = 8'h45;
   localparam logic [7:0] IEND_2   = 8'h4E;
   localparam logic [7:0] IEND_3   = 8'h44;
   localparam logic [7:0] FTYP_0   = 8'h66;
   localparam logic [7:0] FTYP_1   = 8'h74;
   localparam logic [7:0] FTYP_2   = 8'h79;
   localparam logic [7:0] FTYP_3   = 8'h70;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic [BASE_W-1:0] base_offset;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [START_W-1:0]    start_offset;
      logic [FILE_LEN_W-1:0] file_length;
      logic [KIND_W-1:0]     kind;
      logic [CONF_W-1:0]     confidence;
      logic                  truncated;
      logic                  final_record;
   } rsp_type;

   // Which record the controller asks the datapath to log.
   typedef enum logic [2:0] {
      EMIT_NONE        = 3'd0,
      EMIT_JPG_EXACT   = 3'd1,
      EMIT_JPG_DEFAULT = 3'd2,
      EMIT_PNG_EXACT   = 3'd3,
      EMIT_PNG_DEFAULT = 3'd4,
      EMIT_MP4         = 3'd5
   } emit_type;

   // Where the byte window restarts.
   typedef enum logic [2:0] {
      JMP_NONE  = 3'd0,
      JMP_ZERO  = 3'd1,
      JMP_P2    = 3'd2,
      JMP_P3    = 3'd3,
      JMP_P8    = 3'd4,
      JMP_R1025 = 3'd5,
      JMP_P1M   = 3'd6
   } jump_type;

   typedef struct packed {
      logic     load_en;
      logic     scan_init;
      logic     stream;
      logic     save_pos;
      emit_type emit;
      jump_type jump;
      logic     out_read;
      logic     out_load;
      logic     out_next;
      logic     chunk_clear;
   } ctl_cmd_type;

   typedef struct packed {
      logic win_full;
      logic jpg_hdr;
      logic png_hdr;
      logic mp4_hdr;
      logic jpg_ftr;
      logic png_ftr;
      logic hdr_end;
      logic jpg_end;
      logic png_end;
      logic out_final;
   } dp_stat_type;

endpackage

// ----- rtl/media_signature_carver.sv -----
// Loading stores each accepted byte that fits in the chunk memory. After the final byte the
// scan walks the stored chunk at one position per cycle, and each time the walk restarts
// elsewhere the window refills through the single read port of the chunk memory; each result
// then goes through record read, response load and a hold until taken; one chunk at a time.
// Reset is synchronous and clears the control state; the chunk and record memories are not
// cleared, and no clearing pass is needed since only bytes of the current chunk decide the results.
module media_signature_carver #(
   parameter int CHUNK_BYTES = 65536,
   parameter int MAX_RECORDS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  msc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output msc_pkg::rsp_type rsp_data
);
   import msc_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   msc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   msc_datapath #(
      .CHUNK_BYTES (CHUNK_BYTES),
      .MAX_RECORDS (MAX_RECORDS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ----- rtl/msc_ctrl.sv -----
// Controller of the media signature carver: load, header walk, footer walks and
// result delivery. Uses msc_pkg; drives the datapath only through ctl_cmd_type.
module msc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  msc_pkg::dp_stat_type stat,
   output msc_pkg::ctl_cmd_type cmd
);
   import msc_pkg::*;

   localparam logic [2:0] S_LOAD     = 3'd0;
   localparam logic [2:0] S_HDR      = 3'd1;
   localparam logic [2:0] S_JPG      = 3'd2;
   localparam logic [2:0] S_PNG      = 3'd3;
   localparam logic [2:0] S_OUT_RD   = 3'd4;
   localparam logic [2:0] S_OUT_LD   = 3'd5;
   localparam logic [2:0] S_OUT_HOLD = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.emit  = EMIT_NONE;
      cmd.jump  = JMP_NONE;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_en = 1'b1;
               if (req_last) begin
                  cmd.scan_init = 1'b1;
                  cmd.jump      = JMP_ZERO;
                  state_in      = S_HDR;
               end
            end
         end
         S_HDR: begin
            cmd.stream = 1'b1;
            if (stat.hdr_end) begin
               state_in = S_OUT_RD;
            end else if (stat.win_full) begin
               if (stat.jpg_hdr) begin
                  cmd.save_pos = 1'b1;
                  cmd.jump     = JMP_P3;
                  state_in     = S_JPG;
               end else if (stat.png_hdr) begin
                  cmd.save_pos = 1'b1;
                  cmd.jump     = JMP_P8;
                  state_in     = S_PNG;
               end else if (stat.mp4_hdr) begin
                  cmd.emit = EMIT_MP4;
                  cmd.jump = JMP_P1M;
               end
            end
         end
         S_JPG: begin
            cmd.stream = 1'b1;
            if (stat.jpg_end) begin
               cmd.emit = EMIT_JPG_DEFAULT;
               cmd.jump = JMP_R1025;
               state_in = S_HDR;
            end else if (stat.win_full && stat.jpg_ftr) begin
               cmd.emit = EMIT_JPG_EXACT;
               cmd.jump = JMP_P2;
               state_in = S_HDR;
            end
         end
         S_PNG: begin
            cmd.stream = 1'b1;
            if (stat.png_end) begin
               cmd.emit = EMIT_PNG_DEFAULT;
               cmd.jump = JMP_R1025;
               state_in = S_HDR;
            end else if (stat.win_full && stat.png_ftr) begin
               cmd.emit = EMIT_PNG_EXACT;
               cmd.jump = JMP_P8;
               state_in = S_HDR;
            end
         end
         S_OUT_RD: begin
            cmd.out_read = 1'b1;
            state_in     = S_OUT_LD;
         end
         S_OUT_LD: begin
            cmd.out_load = 1'b1;
            state_in     = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (stat.out_final) begin
                  cmd.chunk_clear = 1'b1;
                  state_in        = S_LOAD;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // No byte may be taken while a response is on offer.
   a_no_load_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a response is pending");

   a_last_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=> (state_ff == S_HDR))
      else $error("final byte did not start the scan");

   a_load_presents: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT_LD) |=> rsp_valid)
      else $error("loaded response not presented");

endmodule

// ----- rtl/msc_datapath.sv -----
// Datapath of the media signature carver: chunk memory, eight-byte scan window,
// signature compares, record memory and the response register. Uses msc_pkg.
module msc_datapath #(
   parameter int CHUNK_BYTES = 65536,
   parameter int MAX_RECORDS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  msc_pkg::req_type     req_data,
   input  msc_pkg::ctl_cmd_type cmd,
   output msc_pkg::dp_stat_type stat,
   output msc_pkg::rsp_type     rsp_data
);
   import msc_pkg::*;

   localparam int ADDR_W = $clog2(CHUNK_BYTES);
   localparam int LEN_W  = $clog2(CHUNK_BYTES + 1);
   localparam int POS_W  = ((LEN_W > 21) ? LEN_W : 21) + 1;
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam int REC_AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int REC_W  = ADDR_W + FILE_LEN_W + KIND_W + CONF_W;
   localparam logic [LEN_W-1:0] CHUNK_LEN = LEN_W'(CHUNK_BYTES);
   localparam logic [CNT_W-1:0] REC_MAX   = CNT_W'(MAX_RECORDS);

   logic [7:0]       chunk_mem [CHUNK_BYTES];
   logic [REC_W-1:0] rec_mem [MAX_RECORDS];

   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BASE_W-1:0] base_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [3:0]        fill_ff, fill_in;
   logic              rvalid_ff, rvalid_in;
   logic [7:0]        rdata_ff;
   logic [7:0]        win_ff [WIN_BYTES];
   logic [7:0]        win_in [WIN_BYTES];
   logic [POS_W-1:0]  rec_pos_ff;
   logic [CNT_W-1:0]  rec_cnt_ff, rec_cnt_in;
   logic              trunc_ff, trunc_in;
   logic [REC_AW-1:0] out_idx_ff, out_idx_in;
   logic [REC_W-1:0]  rec_rdata_ff;
   rsp_type           rsp_ff, rsp_in;

   logic                  store_en;
   logic                  emit_valid;
   logic                  rec_room;
   logic [POS_W-1:0]      jump_pos;
   logic [POS_W-1:0]      emit_pos;
   logic [FILE_LEN_W-1:0] emit_len;
   logic [KIND_W-1:0]     emit_kind;
   logic [CONF_W-1:0]     emit_conf;
   logic [REC_W-1:0]      rec_wdata;
   logic [POS_W-1:0]      len_pos;
   logic [ADDR_W-1:0]     rd_pos;
   logic [FILE_LEN_W-1:0] rd_len;
   logic [KIND_W-1:0]     rd_kind;
   logic [CONF_W-1:0]     rd_conf;

   assign store_en   = cmd.load_en && (count_ff < CHUNK_LEN);
   assign emit_valid = (cmd.emit != EMIT_NONE);
   assign rec_room   = (rec_cnt_ff < REC_MAX);
   assign len_pos    = POS_W'(count_ff);

   always_comb begin
      count_in = count_ff;
      if (cmd.chunk_clear) begin
         count_in = '0;
      end else if (store_en) begin
         count_in = count_ff + LEN_W'(1);
      end
   end

   always_comb begin
      case (cmd.jump)
         JMP_P2:    jump_pos = pos_ff + POS_W'(2);
         JMP_P3:    jump_pos = pos_ff + POS_W'(3);
         JMP_P8:    jump_pos = pos_ff + POS_W'(8);
         JMP_R1025: jump_pos = rec_pos_ff + POS_W'(SKIP_NO_FOOTER);
         JMP_P1M:   jump_pos = pos_ff + POS_W'(SKIP_MP4);
         default:   jump_pos = '0;
      endcase
   end

   // While streaming, reads go one address a cycle; a restart drops the read in flight and
   // refills the window from the new position.
   always_comb begin
      pos_in     = pos_ff;
      rd_addr_in = rd_addr_ff;
      fill_in    = fill_ff;
      rvalid_in  = 1'b0;
      for (int k = 0; k < WIN_BYTES; k++) begin
         win_in[k] = win_ff[k];
      end
      if (cmd.jump != JMP_NONE) begin
         pos_in     = jump_pos;
         rd_addr_in = jump_pos;
         fill_in    = '0;
      end else begin
         rvalid_in = cmd.stream;
         if (cmd.stream) begin
            rd_addr_in = rd_addr_ff + POS_W'(1);
         end
         if (rvalid_ff) begin
            for (int k = 0; k < WIN_BYTES - 1; k++) begin
               win_in[k] = win_ff[k + 1];
            end
            win_in[WIN_BYTES - 1] = rdata_ff;
            if (fill_ff == WIN_FILL) begin
               pos_in = pos_ff + POS_W'(1);
            end else begin
               fill_in = fill_ff + 4'd1;
            end
         end
      end
   end

   always_comb begin
      emit_pos  = rec_pos_ff;
      emit_len  = LEN_DEFAULT;
      emit_kind = KIND_NONE;
      emit_conf = CONF_DEFAULT;
      case (cmd.emit)
         EMIT_JPG_EXACT: begin
            emit_len  = FILE_LEN_W'(pos_ff + POS_W'(2) - rec_pos_ff);
            emit_kind = KIND_JPEG;
            emit_conf = CONF_EXACT;
         end
         EMIT_JPG_DEFAULT: begin
            emit_kind = KIND_JPEG;
         end
         EMIT_PNG_EXACT: begin
            emit_len  = FILE_LEN_W'(pos_ff + POS_W'(8) - rec_pos_ff);
            emit_kind = KIND_PNG;
            emit_conf = CONF_EXACT;
         end
         EMIT_PNG_DEFAULT: begin
            emit_kind = KIND_PNG;
         end
         EMIT_MP4: begin
            emit_pos  = pos_ff;
            emit_len  = LEN_MP4;
            emit_kind = KIND_MP4;
            emit_conf = CONF_MP4;
         end
         default: begin
            emit_kind = KIND_NONE;
         end
      endcase
      rec_wdata = {emit_pos[ADDR_W-1:0], emit_len, emit_kind, emit_conf};
   end

   always_comb begin
      rec_cnt_in = rec_cnt_ff;
      trunc_in   = trunc_ff;
      out_idx_in = out_idx_ff;
      if (cmd.scan_init) begin
         rec_cnt_in = '0;
         trunc_in   = 1'b0;
         out_idx_in = '0;
      end else begin
         if (emit_valid) begin
            if (rec_room) begin
               rec_cnt_in = rec_cnt_ff + CNT_W'(1);
            end else begin
               trunc_in = 1'b1;
            end
         end
         if (cmd.out_next) begin
            out_idx_in = out_idx_ff + REC_AW'(1);
         end
      end
   end

   assign rd_pos  = rec_rdata_ff[REC_W-1 -: ADDR_W];
   assign rd_len  = rec_rdata_ff[KIND_W + CONF_W +: FILE_LEN_W];
   assign rd_kind = rec_rdata_ff[CONF_W +: KIND_W];
   assign rd_conf = rec_rdata_ff[CONF_W-1:0];

   always_comb begin
      rsp_in = rsp_ff;
      if (rec_cnt_ff == '0) begin
         rsp_in              = '0;
         rsp_in.kind         = KIND_NONE;
         rsp_in.final_record = 1'b1;
      end else begin
         rsp_in.start_offset = {1'b0, base_ff} + START_W'(rd_pos);
         rsp_in.file_length  = rd_len;
         rsp_in.kind         = rd_kind;
         rsp_in.confidence   = rd_conf;
         rsp_in.truncated    = trunc_ff;
         rsp_in.final_record = ((CNT_W'(out_idx_ff) + CNT_W'(1)) == rec_cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         chunk_mem[count_ff[ADDR_W-1:0]] <= req_data.data_byte;
      end
      if (cmd.stream) begin
         rdata_ff <= chunk_mem[rd_addr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid && rec_room) begin
         rec_mem[rec_cnt_ff[REC_AW-1:0]] <= rec_wdata;
      end
      if (cmd.out_read) begin
         rec_rdata_ff <= rec_mem[out_idx_ff];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_en && (count_ff == '0)) begin
         base_ff <= req_data.base_offset;
      end
      if (cmd.save_pos) begin
         rec_pos_ff <= pos_ff;
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
      pos_ff     <= pos_in;
      rd_addr_ff <= rd_addr_in;
      for (int k = 0; k < WIN_BYTES; k++) begin
         win_ff[k] <= win_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         fill_ff    <= '0;
         rvalid_ff  <= 1'b0;
         rec_cnt_ff <= '0;
         trunc_ff   <= 1'b0;
         out_idx_ff <= '0;
      end else begin
         count_ff   <= count_in;
         fill_ff    <= fill_in;
         rvalid_ff  <= rvalid_in;
         rec_cnt_ff <= rec_cnt_in;
         trunc_ff   <= trunc_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_comb begin
      stat.win_full = (fill_ff == WIN_FILL);
      stat.jpg_hdr  = (win_ff[0] == JPG_MARK) && (win_ff[1] == JPG_SOI) &&
                      (win_ff[2] == JPG_MARK);
      stat.png_hdr  = (win_ff[0] == PNG_SIG0) && (win_ff[1] == PNG_SIG1) &&
                      (win_ff[2] == PNG_SIG2) && (win_ff[3] == PNG_SIG3);
      stat.mp4_hdr  = (win_ff[4] == FTYP_0) && (win_ff[5] == FTYP_1) &&
                      (win_ff[6] == FTYP_2) && (win_ff[7] == FTYP_3);
      stat.jpg_ftr  = (win_ff[0] == JPG_MARK) && (win_ff[1] == JPG_EOI);
      stat.png_ftr  = (win_ff[0] == IEND_0) && (win_ff[1] == IEND_1) &&
                      (win_ff[2] == IEND_2) && (win_ff[3] == IEND_3);
      stat.hdr_end  = !((pos_ff + POS_W'(8)) < len_pos);
      stat.jpg_end  = !((pos_ff + POS_W'(1)) < len_pos);
      stat.png_end  = !((pos_ff + POS_W'(11)) < len_pos);
      stat.out_final = rsp_ff.final_record;
   end

   assign rsp_data = rsp_ff;

   a_rec_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rec_cnt_ff <= REC_MAX)
      else $error("record count beyond the cap");

   a_jump_flushes: assert property (@(posedge clock) disable iff (reset)
      (cmd.jump != JMP_NONE) |=> ((fill_ff == '0) && !rvalid_ff))
      else $error("window not flushed after a restart");

   a_cap_sets_trunc: assert property (@(posedge clock) disable iff (reset)
      (emit_valid && !rec_room && !cmd.scan_init) |=> trunc_ff)
      else $error("dropped record did not set the truncated flag");

endmodule

// ----- tb/sv/media_signature_carver_tb.sv -----
// Self-checking testbench for media_signature_carver: loads chunks of bytes, predicts the
// carved records of each chunk and checks every response in order. Depends on msc_pkg.
`timescale 1ns / 100ps

module media_signature_carver_tb;
   import msc_pkg::*;

   localparam int          CHUNK_BYTES = 65536;
   localparam int          MAX_RECORDS = 64;
   localparam int unsigned CYCLE_LIMIT = 6_000_000;
   localparam int          RANDOM_ITEMS = 330;
   localparam int          RANDOM_RESULTS = 48;
   localparam int          CALM_ITEMS = 280;

   localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
   localparam logic [23:0] JPEG_HEAD = {JPG_MARK, JPG_SOI, JPG_MARK};
   localparam logic [15:0] JPEG_TAIL = {JPG_MARK, JPG_EOI};
   localparam logic [31:0] PNG_HEAD  = {PNG_SIG0, PNG_SIG1, PNG_SIG2, PNG_SIG3};
   localparam logic [31:0] IEND_TAG  = {IEND_0, IEND_1, IEND_2, IEND_3};
   localparam logic [31:0] FTYP_TAG  = {FTYP_0, FTYP_1, FTYP_2, FTYP_3};

   typedef enum logic [3:0] {
      PAT_ZERO,
      PAT_ONES,
      PAT_RANDOM,
      PAT_JPEG_EXACT,
      PAT_JPEG_OPEN,
      PAT_PNG_EXACT,
      PAT_PNG_OPEN,
      PAT_MP4,
      PAT_JPEG_RUN,
      PAT_OVERFLOW
   } chunk_pattern_e;

   typedef struct packed {
      chunk_pattern_e    pattern;
      logic [31:0]       count;
      logic [BASE_W-1:0] origin;
      logic              expect_none;
   } chunk_plan_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Shadow of the block: stored bytes of the current chunk and its origin.
   logic [7:0]        chunk_copy [0:CHUNK_BYTES-1];
   int unsigned       stored;
   logic [BASE_W-1:0] chunk_origin;
   bit                over_cap;
   rsp_type           found_records [$];

   rsp_type         records_due [$];
   logic [7:0]      chunk_bytes [$];
   chunk_plan_type  directed_plan [$];
   int              mismatches;
   int unsigned     cycles;
   bit              calm;

   media_signature_carver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("media_signature_carver: mismatch");
         $finish;
      end
   end

   function automatic logic [BASE_W-1:0] random_base();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[BASE_W-1:0];
   endfunction

   function automatic void log_record(int unsigned at, logic [FILE_LEN_W-1:0] length,
                                      logic [KIND_W-1:0] kind, logic [CONF_W-1:0] conf);
      rsp_type rec;
      if (found_records.size() >= MAX_RECORDS) begin
         over_cap = 1'b1;
         return;
      end
      rec = '0;
      rec.start_offset = {1'b0, chunk_origin} + at;
      rec.file_length  = length;
      rec.kind         = kind;
      rec.confidence   = conf;
      found_records.push_back(rec);
   endfunction

   // Walks the stored chunk the way the block does and leaves its records in found_records.
   function automatic void carve_chunk();
      int unsigned len;
      int unsigned pos;
      int unsigned j;
      int unsigned eof;
      int          k;
      bit          hit;
      rsp_type     rec;
      found_records.delete();
      over_cap = 1'b0;
      len = stored;
      pos = 0;
      eof = 0;
      while (len > 8 && pos < len - 8) begin
         if (chunk_copy[pos] == JPG_MARK && chunk_copy[pos+1] == JPG_SOI &&
             chunk_copy[pos+2] == JPG_MARK) begin
            hit = 1'b0;
            j = pos + 3;
            while (!hit && j + 1 < len) begin
               if (chunk_copy[j] == JPG_MARK && chunk_copy[j+1] == JPG_EOI) begin
                  hit = 1'b1;
                  eof = j + 2;
               end
               j++;
            end
            if (hit) begin
               log_record(pos, eof - pos, KIND_JPEG, CONF_EXACT);
               pos = eof;
            end else begin
               log_record(pos, LEN_DEFAULT, KIND_JPEG, CONF_DEFAULT);
               pos = pos + SKIP_NO_FOOTER;
            end
         end else if (chunk_copy[pos] == PNG_SIG0 && chunk_copy[pos+1] == PNG_SIG1 &&
                      chunk_copy[pos+2] == PNG_SIG2 && chunk_copy[pos+3] == PNG_SIG3) begin
            hit = 1'b0;
            j = pos + 8;
            while (!hit && j + 11 < len) begin
               if (chunk_copy[j] == IEND_0 && chunk_copy[j+1] == IEND_1 &&
                   chunk_copy[j+2] == IEND_2 && chunk_copy[j+3] == IEND_3) begin
                  hit = 1'b1;
                  eof = j + 8;
               end
               j++;
            end
            if (hit) begin
               log_record(pos, eof - pos, KIND_PNG, CONF_EXACT);
               pos = eof;
            end else begin
               log_record(pos, LEN_DEFAULT, KIND_PNG, CONF_DEFAULT);
               pos = pos + SKIP_NO_FOOTER;
            end
         end else if (chunk_copy[pos+4] == FTYP_0 && chunk_copy[pos+5] == FTYP_1 &&
                      chunk_copy[pos+6] == FTYP_2 && chunk_copy[pos+7] == FTYP_3) begin
            log_record(pos, LEN_MP4, KIND_MP4, CONF_MP4);
            pos = pos + SKIP_MP4;
         end else begin
            pos++;
         end
      end
      if (found_records.size() == 0) begin
         rec = '0;
         rec.kind = KIND_NONE;
         rec.final_record = 1'b1;
         found_records.push_back(rec);
      end else begin
         for (k = 0; k < found_records.size(); k++) begin
            rec = found_records[k];
            rec.truncated = over_cap;
            rec.final_record = (k == found_records.size() - 1);
            found_records[k] = rec;
         end
      end
   endfunction

   function automatic void absorb_byte(req_type r);
      if (stored == 0)
         chunk_origin = r.base_offset;
      // Bytes past the end of the store are dropped, but a final one still starts the scan.
      if (stored < CHUNK_BYTES) begin
         chunk_copy[stored] = r.data_byte;
         stored++;
      end
      if (r.last) begin
         carve_chunk();
         stored = 0;
      end
   endfunction

   // Pushes the low n bytes of w, most significant first.
   function automatic void put_word(logic [63:0] w, int n);
      int k;
      for (k = n - 1; k >= 0; k--)
         chunk_bytes.push_back(w[k*8 +: 8]);
   endfunction

   function automatic void put_noise(int n);
      repeat (n) chunk_bytes.push_back($urandom);
   endfunction

   // Random byte with a strong lean toward the signature bytes.
   function automatic logic [7:0] salted_byte();
      case ($urandom_range(0, 15))
         0:  return JPG_MARK;
         1:  return JPG_SOI;
         2:  return JPG_EOI;
         3:  return PNG_SIG0;
         4:  return PNG_SIG1;
         5:  return PNG_SIG2;
         6:  return PNG_SIG3;
         7:  return IEND_0;
         8:  return IEND_1;
         9:  return IEND_3;
         10: return FTYP_0;
         11: return FTYP_1;
         12: return FTYP_2;
         13: return FTYP_3;
         default: return $urandom;
      endcase
   endfunction

   function automatic void build_chunk(chunk_pattern_e pattern, int unsigned count);
      chunk_bytes.delete();
      case (pattern)
         PAT_ZERO:   repeat (count) chunk_bytes.push_back(8'h00);
         PAT_ONES:   repeat (count) chunk_bytes.push_back(8'hFF);
         PAT_RANDOM: put_noise(count);
         PAT_JPEG_RUN: begin
            repeat (count) begin
               put_word(JPEG_HEAD, 3);
               put_word(JPEG_TAIL, 2);
            end
            repeat (9) chunk_bytes.push_back(8'h00);
         end
         PAT_OVERFLOW: begin
            // The header sits near the end of the store; its footer lies in the dropped bytes.
            repeat (count) chunk_bytes.push_back(8'h00);
            chunk_bytes[CHUNK_BYTES-40] = JPG_MARK;
            chunk_bytes[CHUNK_BYTES-39] = JPG_SOI;
            chunk_bytes[CHUNK_BYTES-38] = JPG_MARK;
            chunk_bytes[CHUNK_BYTES+1]  = JPG_MARK;
            chunk_bytes[CHUNK_BYTES+2]  = JPG_EOI;
         end
         default: begin
            repeat (3) chunk_bytes.push_back(8'h00);
            case (pattern)
               PAT_JPEG_EXACT: begin
                  put_word(JPEG_HEAD, 3);
                  put_word(16'h1122, 2);
                  put_word(JPEG_TAIL, 2);
               end
               PAT_JPEG_OPEN: put_word(JPEG_HEAD, 3);
               PAT_PNG_EXACT: begin
                  put_word(PNG_HEAD, 4);
                  put_word(32'h0D0A1A0A, 4);
                  put_word(IEND_TAG, 4);
                  put_word(32'hAE426082, 4);
               end
               PAT_PNG_OPEN: put_word(PNG_HEAD, 4);
               PAT_MP4: begin
                  put_word(32'h00000018, 4);
                  put_word(FTYP_TAG, 4);
               end
               default: ;
            endcase
            while (chunk_bytes.size() < count)
               chunk_bytes.push_back(8'h00);
            while (chunk_bytes.size() > count)
               void'(chunk_bytes.pop_back());
         end
      endcase
   endfunction

   // Mostly well-formed files with random content, the rest noise and broken signatures.
   function automatic void build_random_chunk();
      int mode;
      int target;
      chunk_bytes.delete();
      mode = $urandom_range(0, 9);
      target = $urandom_range(9, 64);
      if (mode < 7) begin
         while (chunk_bytes.size() < target) begin
            case ($urandom_range(0, 7))
               0: put_noise($urandom_range(1, 6));
               1: begin
                  put_word(JPEG_HEAD, 3);
                  put_noise($urandom_range(0, 6));
                  put_word(JPEG_TAIL, 2);
               end
               2: put_word(JPEG_HEAD, 3);
               3: begin
                  put_word(PNG_HEAD, 4);
                  put_noise($urandom_range(0, 10));
                  put_word(IEND_TAG, 4);
                  put_noise(4);
               end
               4: put_word(PNG_HEAD, 4);
               5: begin
                  put_noise(4);
                  put_word(FTYP_TAG, 4);
               end
               6: begin
                  case ($urandom_range(0, 2))
                     0: put_word(JPEG_HEAD[23:8], 2);
                     1: put_word(PNG_HEAD[31:8], 3);
                     default: put_word(FTYP_TAG[31:8], 3);
                  endcase
               end
               default: repeat ($urandom_range(1, 4)) chunk_bytes.push_back(8'h00);
            endcase
         end
         put_noise($urandom_range(0, 9));
      end else if (mode == 7) begin
         put_noise($urandom_range(9, 48));
      end else if (mode == 8) begin
         repeat ($urandom_range(1, 8)) chunk_bytes.push_back(salted_byte());
      end else begin
         repeat (target) chunk_bytes.push_back(salted_byte());
      end
   endfunction

   task automatic plan_chunk(chunk_pattern_e pattern, int unsigned count,
                             logic [BASE_W-1:0] origin, bit expect_none);
      chunk_plan_type row;
      row.pattern     = pattern;
      row.count       = count;
      row.origin      = origin;
      row.expect_none = expect_none;
      directed_plan.push_back(row);
   endtask

   // Drives one request and returns at the edge that accepts it.
   task automatic put_request(req_type r);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_chunk(logic [BASE_W-1:0] origin, bit expect_none);
      req_type r;
      rsp_type rec;
      int      k;
      for (k = 0; k < chunk_bytes.size(); k++) begin
         r.data_byte   = chunk_bytes[k];
         r.base_offset = (k == 0) ? origin : random_base();
         r.last        = (k == chunk_bytes.size() - 1);
         put_request(r);
         absorb_byte(r);
      end
      if (expect_none) begin
         rec = '0;
         rec.kind = KIND_NONE;
         rec.final_record = 1'b1;
         records_due.push_back(rec);
      end else begin
         for (k = 0; k < found_records.size(); k++)
            records_due.push_back(found_records[k]);
      end
   endtask

   task automatic check_record(rsp_type want, rsp_type got);
      if (got.start_offset !== want.start_offset) begin
         $error("start_offset: expected %0h, actual %0h", want.start_offset, got.start_offset);
         mismatches++;
      end
      if (got.file_length !== want.file_length) begin
         $error("file_length: expected %0d, actual %0d", want.file_length, got.file_length);
         mismatches++;
      end
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, actual %0d", want.kind, got.kind);
         mismatches++;
      end
      if (got.confidence !== want.confidence) begin
         $error("confidence: expected %0d, actual %0d", want.confidence, got.confidence);
         mismatches++;
      end
      if (got.truncated !== want.truncated) begin
         $error("truncated: expected %0d, actual %0d", want.truncated, got.truncated);
         mismatches++;
      end
      if (got.final_record !== want.final_record) begin
         $error("final_record: expected %0d, actual %0d", want.final_record, got.final_record);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (records_due.size() == 0) begin
            $error("rsp_data: record %0h arrived with no request outstanding", rsp_data);
            mismatches++;
         end else begin
            check_record(records_due.pop_front(), rsp_data);
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      chunk_plan_type row;
      int             k;
      int             random_items;
      int             random_results;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      stored       = 0;
      chunk_origin = '0;
      mismatches   = 0;
      cycles       = 0;
      calm         = 1'b0;

      plan_chunk(PAT_ZERO, 1, BASE_MAX, 1'b1);
      plan_chunk(PAT_ONES, 9, '0, 1'b1);
      // Eight bytes or fewer are never scanned, signature or not.
      plan_chunk(PAT_JPEG_EXACT, 8, random_base(), 1'b1);
      // The header lands just past the last scanned position.
      plan_chunk(PAT_JPEG_EXACT, 11, random_base(), 1'b1);
      plan_chunk(PAT_JPEG_EXACT, 12, '0, 1'b0);
      plan_chunk(PAT_JPEG_EXACT, 30, BASE_MAX, 1'b0);
      plan_chunk(PAT_JPEG_OPEN, 30, random_base(), 1'b0);
      plan_chunk(PAT_PNG_EXACT, 40, random_base(), 1'b0);
      plan_chunk(PAT_PNG_OPEN, 40, random_base(), 1'b0);
      // The footer falls outside the window in which the search looks for it.
      plan_chunk(PAT_PNG_EXACT, 22, random_base(), 1'b0);
      plan_chunk(PAT_MP4, 20, BASE_MAX, 1'b0);
      plan_chunk(PAT_ZERO, 64, random_base(), 1'b1);
      plan_chunk(PAT_JPEG_RUN, MAX_RECORDS, random_base(), 1'b0);
      plan_chunk(PAT_JPEG_RUN, MAX_RECORDS + 6, random_base(), 1'b0);
      plan_chunk(PAT_OVERFLOW, CHUNK_BYTES + 5, random_base(), 1'b0);
      plan_chunk(PAT_RANDOM, 24, random_base(), 1'b0);
      plan_chunk(PAT_ONES, 1, random_base(), 1'b1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < directed_plan.size(); k++) begin
         row = directed_plan[k];
         build_chunk(row.pattern, row.count);
         send_chunk(row.origin, row.expect_none);
      end

      random_items = 0;
      random_results = 0;
      while (random_items < RANDOM_ITEMS || random_results < RANDOM_RESULTS) begin
         build_random_chunk();
         random_items += chunk_bytes.size();
         if (random_items >= CALM_ITEMS)
            calm = 1'b1;
         send_chunk(random_base(), 1'b0);
         random_results += found_records.size();
      end
      req_valid <= 1'b0;

      while (records_due.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (mismatches == 0)
         $display("media_signature_carver: match");
      else
         $display("media_signature_carver: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/msc_pkg.sv
rtl/msc_ctrl.sv
rtl/msc_datapath.sv
rtl/media_signature_carver.sv
tb/sv/media_signature_carver_tb.sv
